>>> hdl/dbfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfm_pkg
// Shared types and constants of the debounced battery fault monitor.
// ----------------------------------------------------------------------------
package dbfm_pkg;

	localparam int VOLT_W = 16;
	localparam int TEMP_W = 16;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 16;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_UV_LIMIT = 3'd1;
	localparam logic [IDX_W-1:0] REG_OV_LIMIT = 3'd2;
	localparam logic [IDX_W-1:0] REG_OT_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_DB_LIMIT = 3'd4;

	// reset values
	localparam logic                     RST_ENABLE   = 1'b1;
	localparam logic [VOLT_W-1:0]        RST_UV_LIMIT = 16'd30000;
	localparam logic [VOLT_W-1:0]        RST_OV_LIMIT = 16'd42000;
	localparam logic signed [TEMP_W-1:0] RST_OT_LIMIT = 16'sd600;
	localparam logic [CNT_W-1:0]         RST_DB_LIMIT = 4'd5;

	typedef struct packed {
		logic                     enable;
		logic [VOLT_W-1:0]        undervolt_limit;
		logic [VOLT_W-1:0]        overvolt_limit;
		logic signed [TEMP_W-1:0] overtemp_limit;
		logic [CNT_W-1:0]         debounce_limit;
	} cfg_t;

	typedef struct packed {
		logic                     volt_read_ok;
		logic [VOLT_W-1:0]        cell_min_voltage;
		logic [VOLT_W-1:0]        cell_max_voltage;
		logic                     temp_read_ok;
		logic signed [TEMP_W-1:0] temp_peak;
	} tick_t;

	typedef struct packed {
		logic volt_status;
		logic therm_status;
		logic comm_status;
		logic undervolt_flag;
		logic overvolt_flag;
		logic overtemp_flag;
		logic comm_fault_flag;
		logic critical_flag;
		logic send_voltage_frame;
		logic send_temp_frame;
	} res_t;

endpackage
`default_nettype wire

>>> hdl/dbfm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbfm_core
// Debounce counters, status latches and fault flags; one tick per step.
// ----------------------------------------------------------------------------
module dbfm_core import dbfm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  clr_status,
	input  wire logic  step,
	input  wire tick_t tick,
	output res_t       res
);

	logic [CNT_W-1:0] v_cnt_q, t_cnt_q, c_cnt_q;
	logic [CNT_W-1:0] v_cnt_d, t_cnt_d, c_cnt_d;
	logic v_st_q, t_st_q, c_st_q, under_q, over_q, otemp_q, commf_q, crit_q;
	logic v_st_d, t_st_d, c_st_d, under_d, over_d, otemp_d, commf_d, crit_d;
	logic send_v, send_t;
	logic under, over, otemp;
	logic [CNT_W:0] v_bump, t_bump, c_bump, c_bump0;

	// MSB: limit reached (count clears); low bits: next count
	function automatic logic [CNT_W:0] bump(input logic [CNT_W-1:0] cnt,
			input logic [CNT_W-1:0] lim);
		logic [CNT_W:0] inc;
		inc = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
		if (inc >= {1'b0, lim}) begin
			bump = {1'b1, {CNT_W{1'b0}}};
		end else begin
			bump = {1'b0, inc[CNT_W-1:0]};
		end
	endfunction

	assign under   = tick.cell_min_voltage <= cfg.undervolt_limit;
	assign over    = tick.cell_max_voltage >= cfg.overvolt_limit;
	assign otemp   = tick.temp_peak >= cfg.overtemp_limit;
	assign v_bump  = bump(v_cnt_q, cfg.debounce_limit);
	assign t_bump  = bump(t_cnt_q, cfg.debounce_limit);
	assign c_bump  = bump(c_cnt_q, cfg.debounce_limit);
	// good voltage read clears the comm count before a failed temp read counts
	assign c_bump0 = bump({CNT_W{1'b0}}, cfg.debounce_limit);

	always_comb begin
		v_cnt_d = v_cnt_q;
		t_cnt_d = t_cnt_q;
		c_cnt_d = c_cnt_q;
		v_st_d  = v_st_q;
		t_st_d  = t_st_q;
		c_st_d  = c_st_q;
		under_d = under_q;
		over_d  = over_q;
		otemp_d = otemp_q;
		commf_d = commf_q;
		crit_d  = crit_q;
		send_v  = 1'b0;
		send_t  = 1'b0;
		if (clr_status) begin
			v_st_d = 1'b0;
			t_st_d = 1'b0;
			c_st_d = 1'b0;
		end
		if (step && cfg.enable) begin
			if (tick.volt_read_ok) begin
				c_cnt_d = '0;
				c_st_d  = 1'b0;
				send_v  = 1'b1;
				if (under || over) begin
					if (under) begin
						under_d = 1'b1;
					end else begin
						over_d = 1'b1;
					end
					v_cnt_d = v_bump[CNT_W-1:0];
					if (v_bump[CNT_W]) begin
						v_st_d = 1'b1;
						crit_d = 1'b1;
					end
				end else begin
					v_st_d  = 1'b0;
					v_cnt_d = '0;
					under_d = 1'b0;
					over_d  = 1'b0;
				end
				if (tick.temp_read_ok) begin
					send_t = 1'b1;
					if (otemp) begin
						otemp_d = 1'b1;
						t_cnt_d = t_bump[CNT_W-1:0];
						if (t_bump[CNT_W]) begin
							t_st_d = 1'b1;
							crit_d = 1'b1;
						end
					end else begin
						t_cnt_d = '0;
						t_st_d  = 1'b0;
						otemp_d = 1'b0;
					end
				end else begin
					commf_d = 1'b1;
					c_cnt_d = c_bump0[CNT_W-1:0];
					if (c_bump0[CNT_W]) begin
						c_st_d = 1'b1;
						crit_d = 1'b1;
					end
				end
			end else begin
				commf_d = 1'b1;
				c_cnt_d = c_bump[CNT_W-1:0];
				if (c_bump[CNT_W]) begin
					c_st_d = 1'b1;
					crit_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_cnt_q <= '0;
			t_cnt_q <= '0;
			c_cnt_q <= '0;
			v_st_q  <= 1'b0;
			t_st_q  <= 1'b0;
			c_st_q  <= 1'b0;
			under_q <= 1'b0;
			over_q  <= 1'b0;
			otemp_q <= 1'b0;
			commf_q <= 1'b0;
			crit_q  <= 1'b0;
		end else begin
			v_cnt_q <= v_cnt_d;
			t_cnt_q <= t_cnt_d;
			c_cnt_q <= c_cnt_d;
			v_st_q  <= v_st_d;
			t_st_q  <= t_st_d;
			c_st_q  <= c_st_d;
			under_q <= under_d;
			over_q  <= over_d;
			otemp_q <= otemp_d;
			commf_q <= commf_d;
			crit_q  <= crit_d;
		end
	end

	// result is the state after this tick's update
	assign res.volt_status        = v_st_d;
	assign res.therm_status       = t_st_d;
	assign res.comm_status        = c_st_d;
	assign res.undervolt_flag     = under_d;
	assign res.overvolt_flag      = over_d;
	assign res.overtemp_flag      = otemp_d;
	assign res.comm_fault_flag    = commf_d;
	assign res.critical_flag      = crit_d;
	assign res.send_voltage_frame = send_v;
	assign res.send_temp_frame    = send_t;

endmodule
`default_nettype wire

>>> hdl/debounced_battery_fault_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_battery_fault_monitor
// Debounced voltage, temperature and read-failure monitor, one tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick request: read-OK flags,
//   cell min/max voltage and max temperature. Output channel
//   (out_valid/out_ready) returns exactly one result per tick: three status
//   latches, five fault flags and the two frame-schedule pulses.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while no tick is in flight. Writing 0 to the enable register
//   clears all statuses; unknown indexes are dropped.
//   Path: the input register takes the accepted tick, then the update logic
//   writes the result register.
//   Throughput: one tick per cycle while out_ready holds; the counter update
//   is a single pass of compares between the two registers.
//   Stall: while the result waits on out_ready the input register still
//   takes one more tick, then in_ready drops until the result is taken.
//   Reset: counters, statuses and flags clear; limits load their defaults
//   (enabled, 30000, 42000, 600, debounce 5). No clearing pass.
// ----------------------------------------------------------------------------
module debounced_battery_fault_monitor import dbfm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     volt_read_ok,
	input  wire logic [VOLT_W-1:0]        cell_min_voltage,
	input  wire logic [VOLT_W-1:0]        cell_max_voltage,
	input  wire logic                     temp_read_ok,
	input  wire logic signed [TEMP_W-1:0] temp_peak,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          volt_status,
	output logic                          therm_status,
	output logic                          comm_status,
	output logic                          undervolt_flag,
	output logic                          overvolt_flag,
	output logic                          overtemp_flag,
	output logic                          comm_fault_flag,
	output logic                          critical_flag,
	output logic                          send_voltage_frame,
	output logic                          send_temp_frame,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [IDX_W-1:0]         cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	cfg_t  cfg_q;
	tick_t tick_s1;
	logic  valid_s1;
	res_t  res_next;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;
	logic  step;
	logic  cfg_wr;
	logic  clr_status;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign clr_status = cfg_wr && (cfg_index == REG_ENABLE) && !cfg_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= RST_ENABLE;
			cfg_q.undervolt_limit <= RST_UV_LIMIT;
			cfg_q.overvolt_limit  <= RST_OV_LIMIT;
			cfg_q.overtemp_limit  <= RST_OT_LIMIT;
			cfg_q.debounce_limit  <= RST_DB_LIMIT;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_ENABLE:   cfg_q.enable          <= cfg_data[0];
				REG_UV_LIMIT: cfg_q.undervolt_limit <= cfg_data[VOLT_W-1:0];
				REG_OV_LIMIT: cfg_q.overvolt_limit  <= cfg_data[VOLT_W-1:0];
				REG_OT_LIMIT: cfg_q.overtemp_limit  <= $signed(cfg_data[TEMP_W-1:0]);
				REG_DB_LIMIT: cfg_q.debounce_limit  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.volt_read_ok     <= volt_read_ok;
			tick_s1.cell_min_voltage <= cell_min_voltage;
			tick_s1.cell_max_voltage <= cell_max_voltage;
			tick_s1.temp_read_ok     <= temp_read_ok;
			tick_s1.temp_peak        <= temp_peak;
		end
		if (step) begin
			res_s2 <= res_next;
		end
	end

	dbfm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clr_status (clr_status),
		.step       (step),
		.tick       (tick_s1),
		.res        (res_next)
	);

	assign out_valid          = valid_s2;
	assign volt_status        = res_s2.volt_status;
	assign therm_status       = res_s2.therm_status;
	assign comm_status        = res_s2.comm_status;
	assign undervolt_flag     = res_s2.undervolt_flag;
	assign overvolt_flag      = res_s2.overvolt_flag;
	assign overtemp_flag      = res_s2.overtemp_flag;
	assign comm_fault_flag    = res_s2.comm_fault_flag;
	assign critical_flag      = res_s2.critical_flag;
	assign send_voltage_frame = res_s2.send_voltage_frame;
	assign send_temp_frame    = res_s2.send_temp_frame;

	// temperature is only looked at behind a good voltage read
	a_temp_needs_volt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!send_temp_frame || send_voltage_frame))
		else $error("temp frame without voltage frame");

	// any latched status came through a debounce hit, which sets critical
	a_status_crit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (volt_status || therm_status || comm_status)) |-> critical_flag)
		else $error("status latched without critical flag");

	a_comm_status_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && comm_status) |-> comm_fault_flag)
		else $error("comm status without comm fault flag");

	// a stalled result leaves room for exactly one more request
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("input taken with both stages full");

endmodule
`default_nettype wire
